FILE: hw/rtl/sgcf_pkg.sv
package sgcf_pkg;

    localparam int GRID_COLUMNS_DEF  = 256;
    localparam int GRID_ROWS_DEF     = 256;
    localparam int WINDOW_RADIUS_DEF = 3;

    localparam logic [2:0] CFG_GROUND_Z_LOW  = 3'd0;
    localparam logic [2:0] CFG_GROUND_Z_HIGH = 3'd1;
    localparam logic [2:0] CFG_WALL_Z        = 3'd2;
    localparam logic [2:0] CFG_WALL_LATERAL  = 3'd3;
    localparam logic [2:0] CFG_LABEL_THRESH  = 3'd4;
    localparam logic [2:0] CFG_ELEV_TRUST    = 3'd5;

    localparam logic signed [15:0] RST_GROUND_Z_LOW  = -16'sd80;
    localparam logic signed [15:0] RST_GROUND_Z_HIGH = 16'sd420;
    localparam logic signed [15:0] RST_WALL_Z        = 16'sd800;
    localparam logic [14:0]        RST_WALL_LATERAL  = 15'd2800;
    localparam logic [15:0]        RST_LABEL_THRESH  = 16'd8192;
    localparam logic [15:0]        RST_ELEV_TRUST    = 16'd1638;

    localparam logic [2:0] LABEL_UNKNOWN  = 3'd0;
    localparam logic [2:0] LABEL_GROUND   = 3'd1;
    localparam logic [2:0] LABEL_OBSTACLE = 3'd2;
    localparam logic [2:0] LABEL_WALL     = 3'd3;
    localparam logic [2:0] LABEL_MAX      = 3'd5;

    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] HALF_Q15 = 16'd16384;

    localparam int NUM_W  = 54;
    localparam int DEN_W  = 37;
    localparam int MA_W   = 33;
    localparam int MB_W   = 18;
    localparam int PROD_W = MA_W + MB_W;

    typedef struct packed {
        logic [15:0]        econf;
        logic signed [15:0] elev;
        logic [15:0]        conf;
        logic [15:0]        occ;
        logic [2:0]         label;
    } cell_t;

    localparam cell_t CELL_RESET = '{econf: 16'd0, elev: 16'sd0, conf: 16'd0,
                                     occ: 16'd16384, label: 3'd0};

endpackage

FILE: hw/rtl/sgcf_div.sv
module sgcf_div
    import sgcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             qbit;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign qbit    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: hw/rtl/semantic_grid_cell_fusion.sv
// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    tdata: fuse or query item, tuser: op
// m_axis    out        m_axis_tvalid/tready    tdata: fused cell and ground height
// cfg       in         cfg_we                  cfg_index, cfg_data
//
// After reset a clearing pass writes every cell with s_axis_tready low. s_axis_tready
// is high only in the idle state. A fuse then runs read, seven multiplier steps,
// divider start and wait when a ground label updates the elevation through the
// bit-serial divider (one bit a cycle), write-back and hand-over. A query runs, per
// window cell, address only off the grid, address and QM1 when skipped, address and
// QM1 to QM3 when counted; then finish, the divider if weight remains, and hand-over.
// Off the grid, only hand-over. Hand-over stalls while an unaccepted result is held.
module semantic_grid_cell_fusion
    import sgcf_pkg::*;
#(
    parameter int GRID_COLUMNS  = GRID_COLUMNS_DEF,
    parameter int GRID_ROWS     = GRID_ROWS_DEF,
    parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // inside_grid, cell_x, cell_y, label_given, obs_label, point_lateral_mm,
    // point_z_mm, obs_occupancy, obs_confidence, zero pad
    input  logic [87:0] s_axis_tdata,
    // op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_label, cell_occupancy, cell_confidence, cell_elevation_mm,
    // ground_height_mm, zero pad
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int WIN_N      = 2 * WINDOW_RADIUS + 1;
    localparam int WIN_W      = $clog2(WIN_N);
    localparam int COORD_W    = 15;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FRD   = 4'd2;
    localparam logic [3:0] ST_FMUL  = 4'd3;
    localparam logic [3:0] ST_FDIV  = 4'd4;
    localparam logic [3:0] ST_FDW   = 4'd5;
    localparam logic [3:0] ST_FWR   = 4'd6;
    localparam logic [3:0] ST_QADR  = 4'd7;
    localparam logic [3:0] ST_QM1   = 4'd8;
    localparam logic [3:0] ST_QM2   = 4'd9;
    localparam logic [3:0] ST_QM3   = 4'd10;
    localparam logic [3:0] ST_QFIN  = 4'd11;
    localparam logic [3:0] ST_QDIV  = 4'd12;
    localparam logic [3:0] ST_QDW   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic signed [15:0] gz_low_reg, gz_high_reg, wall_z_reg;
    logic [14:0]        wall_lat_reg;
    logic [15:0]        thresh_reg, trust_reg;

    logic [3:0]  state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [7:0]         x_reg, y_reg;
    logic [2:0]         lbl_reg;
    logic signed [15:0] z_reg;
    logic [15:0]        oocc_reg, c_reg;

    logic [2:0]  step_reg;
    logic [32:0] occ_acc_reg;
    logic [16:0] conf_add_reg, econf_add_reg;
    logic signed [33:0] num_reg;
    logic        div_used_reg;

    logic [WIN_W-1:0] wx_reg, wy_reg;
    logic signed [NUM_W-1:0] wsum_reg;
    logic [DEN_W-1:0]        tsum_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;

    logic [71:0] res_reg;
    logic [71:0] out_data_reg;
    logic        out_valid_reg;

    cell_t             mem [CELL_COUNT];
    cell_t             mem_q_reg;
    cell_t             mem_wd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] fuse_addr;

    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;

    logic        in_op, in_inside, in_given;
    logic [7:0]  in_x, in_y;
    logic [2:0]  in_lbl, cls_lbl, fin_lbl;
    logic signed [15:0] in_lat, in_z;
    logic [15:0] in_occ, in_conf;
    logic signed [16:0] alat;
    logic        in_on_grid;

    logic signed [COORD_W-1:0] cx, cy;
    logic        win_ok, win_last, cell_use;

    logic [16:0] total;
    logic [33:0] num_mag;
    cell_t       new_cell;
    logic [32:0] occ_sum;
    logic [17:0] conf_sum, econf_sum;
    logic [15:0] q16;
    logic [14:0] ground_q;

    assign in_op     = s_axis_tuser;
    assign in_inside = s_axis_tdata[0];
    assign in_x      = s_axis_tdata[8:1];
    assign in_y      = s_axis_tdata[16:9];
    assign in_given  = s_axis_tdata[17];
    assign in_lbl    = s_axis_tdata[20:18];
    assign in_lat    = s_axis_tdata[36:21];
    assign in_z      = s_axis_tdata[52:37];
    assign in_occ    = s_axis_tdata[68:53];
    assign in_conf   = s_axis_tdata[84:69];

    assign alat = in_lat[15] ? -{in_lat[15], in_lat} : {in_lat[15], in_lat};

    always_comb
    begin
        if (in_z >= gz_low_reg && in_z < gz_high_reg)
            cls_lbl = LABEL_GROUND;
        else if (in_z > wall_z_reg && alat > $signed({2'b00, wall_lat_reg}))
            cls_lbl = LABEL_WALL;
        else
            cls_lbl = LABEL_OBSTACLE;
        fin_lbl = in_given ? in_lbl : cls_lbl;
        if (fin_lbl > LABEL_MAX)
            fin_lbl = LABEL_UNKNOWN;
    end

    assign in_on_grid = in_inside && (32'(in_x) < GRID_COLUMNS) && (32'(in_y) < GRID_ROWS);
    assign s_axis_tready = (state_reg == ST_IDLE);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gz_low_reg   <= RST_GROUND_Z_LOW;
            gz_high_reg  <= RST_GROUND_Z_HIGH;
            wall_z_reg   <= RST_WALL_Z;
            wall_lat_reg <= RST_WALL_LATERAL;
            thresh_reg   <= RST_LABEL_THRESH;
            trust_reg    <= RST_ELEV_TRUST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GROUND_Z_LOW:  gz_low_reg   <= cfg_data;
                CFG_GROUND_Z_HIGH: gz_high_reg  <= cfg_data;
                CFG_WALL_Z:        wall_z_reg   <= cfg_data;
                CFG_WALL_LATERAL:  wall_lat_reg <= cfg_data[14:0];
                CFG_LABEL_THRESH:  thresh_reg   <= cfg_data;
                CFG_ELEV_TRUST:    trust_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // window coordinates
    assign cx = $signed(COORD_W'(x_reg)) - COORD_W'(WINDOW_RADIUS) + $signed(COORD_W'(wx_reg));
    assign cy = $signed(COORD_W'(y_reg)) - COORD_W'(WINDOW_RADIUS) + $signed(COORD_W'(wy_reg));
    assign win_ok = !cx[COORD_W-1] && !cy[COORD_W-1]
                    && (cx < $signed(COORD_W'(GRID_COLUMNS)))
                    && (cy < $signed(COORD_W'(GRID_ROWS)));
    assign win_last = (wx_reg == WIN_W'(WIN_N - 1)) && (wy_reg == WIN_W'(WIN_N - 1));
    assign cell_use = (mem_q_reg.label == LABEL_GROUND) && (mem_q_reg.econf > trust_reg);

    assign fuse_addr = ADDR_W'(32'(y_reg) * GRID_COLUMNS + 32'(x_reg));

    // hold the window cell address until its elevation has been used
    always_comb
    begin
        if (state_reg == ST_QADR || state_reg == ST_QM1 || state_reg == ST_QM2)
            rd_addr = ADDR_W'(32'(cy[COORD_W-2:0]) * GRID_COLUMNS + 32'(cx[COORD_W-2:0]));
        else
            rd_addr = fuse_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q_reg <= mem[rd_addr];
    end

    // shared multiplier
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (state_reg == ST_FMUL)
        begin
            case (step_reg)
                3'd0:
                begin
                    ma = MA_W'(mem_q_reg.occ);
                    mb = MB_W'(17'(ONE_Q15) - 17'(c_reg));
                end
                3'd1:
                begin
                    ma = MA_W'(oocc_reg);
                    mb = MB_W'(c_reg);
                end
                3'd2:
                begin
                    ma = MA_W'(c_reg);
                    mb = MB_W'(17'(ONE_Q15) - 17'(mem_q_reg.conf));
                end
                3'd3:
                begin
                    ma = MA_W'(c_reg);
                    mb = MB_W'(17'(ONE_Q15) - 17'(mem_q_reg.econf));
                end
                3'd4:
                begin
                    ma = MA_W'(mem_q_reg.elev);
                    mb = MB_W'(mem_q_reg.econf);
                end
                3'd5:
                begin
                    ma = MA_W'(z_reg);
                    mb = MB_W'(c_reg);
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_QM1)
        begin
            ma = MA_W'(mem_q_reg.conf);
            mb = MB_W'(mem_q_reg.econf);
        end
        else if (state_reg == ST_QM2)
        begin
            ma = MA_W'(prod_reg[30:0]);
            mb = MB_W'(mem_q_reg.elev);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    // fuse result
    assign total   = 17'(mem_q_reg.econf) + 17'(c_reg);
    assign num_mag = num_reg[33] ? 34'(-num_reg) : 34'(num_reg);
    assign occ_sum   = occ_acc_reg + 33'(HALF_Q15);
    assign conf_sum  = 18'(mem_q_reg.conf) + 18'(conf_add_reg);
    assign econf_sum = 18'(mem_q_reg.econf) + 18'(econf_add_reg);
    assign q16       = num_reg[33] ? -div_quot[15:0] : div_quot[15:0];

    always_comb
    begin
        new_cell = mem_q_reg;
        new_cell.occ  = (occ_sum[32:15] > 18'(ONE_Q15)) ? ONE_Q15 : occ_sum[30:15];
        new_cell.conf = (conf_sum > 18'(ONE_Q15)) ? ONE_Q15 : conf_sum[15:0];
        if (c_reg >= thresh_reg || mem_q_reg.label == LABEL_UNKNOWN)
            new_cell.label = lbl_reg;
        if (lbl_reg == LABEL_GROUND)
            new_cell.econf = (econf_sum > 18'(ONE_Q15)) ? ONE_Q15 : econf_sum[15:0];
        if (div_used_reg)
            new_cell.elev = q16;
    end

    assign ground_q = (|div_quot[NUM_W-1:15]) ? 15'h7FFF : div_quot[14:0];

    // divider inputs
    always_comb
    begin
        div_start = (state_reg == ST_FDIV) || (state_reg == ST_QDIV);
        if (state_reg == ST_QDIV)
        begin
            div_num = NUM_W'(wsum_reg) + NUM_W'(tsum_reg >> 1);
            div_den = tsum_reg;
        end
        else
        begin
            div_num = NUM_W'(num_mag) + NUM_W'(total >> 1);
            div_den = DEN_W'(total);
        end
    end

    sgcf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // memory write
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = fuse_addr;
        mem_wd = new_cell;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = CELL_RESET;
        end
        else if (state_reg == ST_FWR)
            mem_we = 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == ADDR_W'(CELL_COUNT - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    if (!in_on_grid)
                        state_next = ST_OUT;
                    else if (in_op)
                        state_next = ST_QADR;
                    else
                        state_next = ST_FRD;
                end
            ST_FRD:
                state_next = ST_FMUL;
            ST_FMUL:
                if (step_reg == 3'd6)
                    state_next = (lbl_reg == LABEL_GROUND && total != 17'd0) ? ST_FDIV : ST_FWR;
            ST_FDIV:
                state_next = ST_FDW;
            ST_FDW:
                if (div_done)
                    state_next = ST_FWR;
            ST_FWR:
                state_next = ST_OUT;
            ST_QADR:
                if (win_ok)
                    state_next = ST_QM1;
                else
                    state_next = win_last ? ST_QFIN : ST_QADR;
            ST_QM1:
                if (cell_use)
                    state_next = ST_QM2;
                else
                    state_next = win_last ? ST_QFIN : ST_QADR;
            ST_QM2:
                state_next = ST_QM3;
            ST_QM3:
                state_next = win_last ? ST_QFIN : ST_QADR;
            ST_QFIN:
                if (tsum_reg > DEN_W'(1) && !wsum_reg[NUM_W-1] && wsum_reg != '0)
                    state_next = ST_QDIV;
                else
                    state_next = ST_OUT;
            ST_QDIV:
                state_next = ST_QDW;
            ST_QDW:
                if (div_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg        <= in_x;
                y_reg        <= in_y;
                lbl_reg      <= fin_lbl;
                z_reg        <= in_z;
                oocc_reg     <= (in_occ > ONE_Q15) ? ONE_Q15 : in_occ;
                c_reg        <= (in_conf > ONE_Q15) ? ONE_Q15 : in_conf;
                step_reg     <= '0;
                div_used_reg <= 1'b0;
                wx_reg       <= '0;
                wy_reg       <= '0;
                wsum_reg     <= '0;
                tsum_reg     <= '0;
                res_reg      <= '0;
            end
            ST_FMUL:
            begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    3'd1: occ_acc_reg <= prod_reg[32:0];
                    3'd2: occ_acc_reg <= occ_acc_reg + prod_reg[32:0];
                    3'd3: conf_add_reg <= 17'((prod_reg[32:0] + 33'(HALF_Q15)) >> 15);
                    3'd4: econf_add_reg <= 17'((prod_reg[32:0] + 33'(HALF_Q15)) >> 15);
                    3'd5: num_reg <= 34'(prod_reg);
                    3'd6: num_reg <= num_reg + 34'(prod_reg);
                    default: ;
                endcase
            end
            ST_FDIV:
                div_used_reg <= 1'b1;
            ST_FWR:
                res_reg <= {6'd0, 15'd0, new_cell.elev, new_cell.conf, new_cell.occ,
                            new_cell.label};
            ST_QM2:
                tsum_reg <= tsum_reg + DEN_W'(prod_reg[30:0]);
            ST_QM3:
                wsum_reg <= wsum_reg + NUM_W'(prod_reg);
            ST_QDW:
                if (div_done)
                    res_reg <= {6'd0, ground_q, 51'd0};
            default: ;
        endcase
        if ((state_reg == ST_QADR && !win_ok) || (state_reg == ST_QM1 && !cell_use)
            || state_reg == ST_QM3)
        begin
            if (wx_reg == WIN_W'(WIN_N - 1))
            begin
                wx_reg <= '0;
                wy_reg <= wy_reg + 1'b1;
            end
            else
                wx_reg <= wx_reg + 1'b1;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= res_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_FWR))
        else $error("cell store written outside clear or fuse write-back");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_FDW || state_reg == ST_QDW))
        else $error("divider finished with no waiting operation");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result not presented after completion");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while an item is in work");

endmodule
